@@ rtl/iir4_pkg.sv @@
// shared constants and types for the fourth-order direct form I IIR filter
// no dependencies; imported by every module of the block
package iir4_pkg;

  // default build of the sample path
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 28;

  // register widths
  localparam int COEF_W          = 32;
  localparam int SCALE_W         = 48;
  localparam int SCALE_FRAC_BITS = 48;
  localparam int SCALE_SPLIT     = 24;
  localparam int NUM_TAPS        = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FB_COEF_Y4   = 3'd0,
    REG_FB_COEF_Y3   = 3'd1,
    REG_FB_COEF_Y2   = 3'd2,
    REG_FB_COEF_Y1   = 3'd3,
    REG_INPUT_SCALE  = 3'd4,
    REG_NUM_MODE     = 3'd5
  } cfg_reg_e;

  // register reset values
  localparam logic signed [COEF_W-1:0] FB_COEF_Y4_RST  = -32'sd249172661;
  localparam logic signed [COEF_W-1:0] FB_COEF_Y3_RST  = 32'sd1015244104;
  localparam logic signed [COEF_W-1:0] FB_COEF_Y2_RST  = -32'sd1551390210;
  localparam logic signed [COEF_W-1:0] FB_COEF_Y1_RST  = 32'sd1053754053;
  localparam logic [SCALE_W-1:0]       INPUT_SCALE_RST = 48'd11177707;
  localparam logic                     NUM_MODE_RST    = 1'b0;

endpackage

@@ rtl/iir4_fb_sum.sv @@
// feedback multiply-accumulate, rounding and saturation of the filter output
// depends on iir4_pkg; combinational, used by iir4_direct_form_filter_top
module iir4_fb_sum
  import iir4_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic signed [SAMPLE_BITS+SCALE_W+4:0] scale_prod_i,
  input  logic signed [SAMPLE_BITS+15:0]        past_y_i [NUM_TAPS],
  input  logic signed [COEF_W-1:0]              coef_i   [NUM_TAPS],
  output logic signed [SAMPLE_BITS+15:0]        wide_o,
  output logic signed [SAMPLE_BITS-1:0]         sample_o,
  output logic                                  saturated_o
);

  localparam int WIDE  = SAMPLE_BITS + 16;
  localparam int PY_LO = WIDE / 2;
  localparam int PY_HI = WIDE - PY_LO;
  localparam int UP    = SCALE_FRAC_BITS - COEF_FRAC_BITS;
  localparam int ACC_W = WIDE + COEF_W + UP + 3;
  localparam int RND_W = ACC_W - SCALE_FRAC_BITS;

  logic signed [ACC_W-1:0] acc;
  logic        [RND_W-1:0] rnd;
  logic                    in_wide;
  logic                    in_samp;

  always_comb begin
    logic signed [PY_HI+COEF_W-1:0] p_hi;
    logic signed [PY_LO+COEF_W:0]   p_lo;
    logic signed [WIDE+COEF_W-1:0]  prod;
    acc = ACC_W'(scale_prod_i);
    for (int i = 0; i < NUM_TAPS; i++) begin
      // split the wide history word so each multiplier stays narrow
      p_hi = $signed(past_y_i[i][WIDE-1:PY_LO]) * coef_i[i];
      p_lo = $signed({1'b0, past_y_i[i][PY_LO-1:0]}) * coef_i[i];
      prod = ((WIDE+COEF_W)'(p_hi) <<< PY_LO) + (WIDE+COEF_W)'(p_lo);
      acc  = acc + (ACC_W'(prod) <<< UP);
    end
    // round half up, then floor shift
    acc = acc + (ACC_W'(1) <<< (SCALE_FRAC_BITS - 1));
    rnd = acc[ACC_W-1:SCALE_FRAC_BITS];
  end

  assign in_wide = (&rnd[RND_W-1:WIDE-1]) | (~|rnd[RND_W-1:WIDE-1]);
  assign in_samp = (&rnd[RND_W-1:SAMPLE_BITS-1]) | (~|rnd[RND_W-1:SAMPLE_BITS-1]);

  always_comb begin
    if (in_wide) begin
      wide_o = rnd[WIDE-1:0];
    end else if (rnd[RND_W-1]) begin
      wide_o = {1'b1, {(WIDE-1){1'b0}}};
    end else begin
      wide_o = {1'b0, {(WIDE-1){1'b1}}};
    end
    if (in_samp) begin
      sample_o = rnd[SAMPLE_BITS-1:0];
    end else if (rnd[RND_W-1]) begin
      sample_o = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sample_o = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  assign saturated_o = ~in_samp;

endmodule

@@ rtl/iir4_direct_form_filter_top.sv @@
// top level of the fourth-order direct form I IIR filter, stream in and out
// depends on iir4_pkg and iir4_fb_sum
//
// The filter takes one sample and gives one filtered word per clock unless the output
// stalls; a word passes the stage one and output registers. Stage one builds the binomial
// feed-forward sum (odd taps negated in mode 1) from the new sample and the four past
// inputs and multiplies it by input_scale; stage two adds the four feedback products on
// the past wide outputs, rounds, saturates and registers the result. The feedback
// recursion in stage two sets this rate. History is cleared at reset. Registers are written
// through the cfg port by the user while the stream is idle; the block does not enforce it.
module iir4_direct_form_filter_top
  import iir4_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,  // sample_in
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,  // filtered_sample
  output logic                                m_axis_tuser,  // saturated
  output logic                                m_axis_tlast,
  input  logic                                cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]               cfg_wdata_i
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int WIDE   = SAMPLE_BITS + 16;
  localparam int FF_W   = SAMPLE_BITS + 4;
  localparam int SP_W   = FF_W + SCALE_W + 1;

  // configuration
  logic signed [COEF_W-1:0]  coef_q [NUM_TAPS];  // index 0 weighs y[n-1]
  logic        [SCALE_W-1:0] scale_q;
  logic                      mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= FB_COEF_Y1_RST;
      coef_q[1] <= FB_COEF_Y2_RST;
      coef_q[2] <= FB_COEF_Y3_RST;
      coef_q[3] <= FB_COEF_Y4_RST;
      scale_q   <= INPUT_SCALE_RST;
      mode_q    <= NUM_MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FB_COEF_Y4:  coef_q[3] <= cfg_wdata_i[COEF_W-1:0];
        REG_FB_COEF_Y3:  coef_q[2] <= cfg_wdata_i[COEF_W-1:0];
        REG_FB_COEF_Y2:  coef_q[1] <= cfg_wdata_i[COEF_W-1:0];
        REG_FB_COEF_Y1:  coef_q[0] <= cfg_wdata_i[COEF_W-1:0];
        REG_INPUT_SCALE: scale_q   <= cfg_wdata_i[SCALE_W-1:0];
        REG_NUM_MODE:    mode_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // handshake
  logic a_valid_q;
  logic m_valid_q;
  logic b_ready;
  logic a_ready;
  logic s_fire;
  logic a_fire;

  assign b_ready       = ~m_valid_q | m_axis_tready;
  assign a_ready       = ~a_valid_q | b_ready;
  assign s_fire        = s_axis_tvalid & a_ready;
  assign a_fire        = a_valid_q & b_ready;
  assign s_axis_tready = a_ready;

  // stage one: feed-forward sum and scale product
  logic signed [SAMPLE_BITS-1:0] x_in;
  logic signed [SAMPLE_BITS-1:0] past_x_q [NUM_TAPS];
  logic signed [SP_W-1:0]        scale_prod_d;
  logic signed [SP_W-1:0]        a_prod_q;
  logic                          a_last_q;

  assign x_in = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);

  always_comb begin
    logic signed [FF_W-1:0]                         t1;
    logic signed [FF_W-1:0]                         t2;
    logic signed [FF_W-1:0]                         t3;
    logic signed [FF_W-1:0]                         ff;
    logic signed [FF_W+SCALE_SPLIT:0]               sp_lo;
    logic signed [FF_W+SCALE_W-SCALE_SPLIT:0]       sp_hi;
    t1 = FF_W'(past_x_q[0]) <<< 2;
    t3 = FF_W'(past_x_q[2]) <<< 2;
    if (mode_q) begin
      t1 = -t1;
      t3 = -t3;
    end
    t2 = (FF_W'(past_x_q[1]) <<< 2) + (FF_W'(past_x_q[1]) <<< 1);
    ff = FF_W'(x_in) + t1 + t2 + t3 + FF_W'(past_x_q[3]);
    sp_lo = ff * $signed({1'b0, scale_q[SCALE_SPLIT-1:0]});
    sp_hi = ff * $signed({1'b0, scale_q[SCALE_W-1:SCALE_SPLIT]});
    scale_prod_d = (SP_W'(sp_hi) <<< SCALE_SPLIT) + SP_W'(sp_lo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      for (int i = 0; i < NUM_TAPS; i++) begin
        past_x_q[i] <= '0;
      end
    end else begin
      if (a_ready) begin
        a_valid_q <= s_axis_tvalid;
      end
      if (s_fire) begin
        past_x_q[0] <= x_in;
        for (int i = 1; i < NUM_TAPS; i++) begin
          past_x_q[i] <= past_x_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      a_prod_q <= scale_prod_d;
      a_last_q <= s_axis_tlast;
    end
  end

  // stage two: feedback recursion and output register
  logic signed [WIDE-1:0]        past_y_q [NUM_TAPS];
  logic signed [WIDE-1:0]        wide_d;
  logic signed [SAMPLE_BITS-1:0] sample_d;
  logic                          sat_d;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_sat_q;
  logic                          out_last_q;

  iir4_fb_sum #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_fb_sum (
    .scale_prod_i(a_prod_q),
    .past_y_i    (past_y_q),
    .coef_i      (coef_q),
    .wide_o      (wide_d),
    .sample_o    (sample_d),
    .saturated_o (sat_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      for (int i = 0; i < NUM_TAPS; i++) begin
        past_y_q[i] <= '0;
      end
    end else begin
      if (b_ready) begin
        m_valid_q <= a_valid_q;
      end
      if (a_fire) begin
        past_y_q[0] <= wide_d;
        for (int i = 1; i < NUM_TAPS; i++) begin
          past_y_q[i] <= past_y_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      out_sample_q <= sample_d;
      out_sat_q    <= sat_d;
      out_last_q   <= a_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = DATA_W'($unsigned(out_sample_q));
  assign m_axis_tuser  = out_sat_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/iir4_checker.sv @@
// port-level checks for the IIR filter top level, attached by bind
// depends on iir4_pkg and iir4_direct_form_filter_top
module iir4_checker
  import iir4_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,  // filtered_sample
  input logic                             m_axis_tuser,  // saturated
  input logic                             m_axis_tlast
);

  localparam logic [SAMPLE_BITS-1:0] SAMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // a stalled output word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // a clipped word sits on one of the sample range bounds
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[SAMPLE_BITS-1:0] == SAMP_MAX || m_axis_tdata[SAMPLE_BITS-1:0] == SAMP_MIN)
    else $error("saturation flag on an unclipped word");

  // input only backs up when the output register is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back pressure");

  // an accepted word passes the stage one register and reaches the output register when not stalled
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("accepted word did not reach the output");

endmodule

bind iir4_direct_form_filter_top iir4_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_iir4_checker (.*);

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// testbench for iir4_direct_form_filter_top: streams samples, predicts every filtered word
// with a bit-exact model of the fourth-order recursion and checks the output stream
// depends on rtl/iir4_pkg.sv and the filter rtl
module tb;
  import iir4_pkg::*;

  localparam int SW       = SAMPLE_BITS_DEF;
  localparam int WIDE_W   = SW + 16;
  localparam int FB_SHIFT = SCALE_FRAC_BITS - COEF_FRAC_BITS_DEF;
  localparam int LIMIT    = 200000;
  localparam int PHASES   = 7;
  localparam int PHASE_ITEMS = 70;

  localparam logic signed [127:0] WIDE_HI = (128'sd1 <<< (WIDE_W - 1)) - 128'sd1;
  localparam logic signed [127:0] WIDE_LO = -(128'sd1 <<< (WIDE_W - 1));
  localparam logic signed [127:0] SAMP_HI = (128'sd1 <<< (SW - 1)) - 128'sd1;
  localparam logic signed [127:0] SAMP_LO = -(128'sd1 <<< (SW - 1));
  localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (SCALE_FRAC_BITS - 1);

  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  // indexes past the end of the register map, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

  typedef struct packed {
    logic [SW-1:0] sample;
    logic          sat;
    logic          last;
  } out_word_t;

  class filter_scoreboard;
    logic signed [COEF_W-1:0] fb_coef [NUM_TAPS]; // index 0 weighs y[n-1]
    logic [SCALE_W-1:0]       scale;
    logic                     alt_taps;
    logic signed [SW-1:0]     x_hist [NUM_TAPS];
    logic signed [WIDE_W-1:0] y_hist [NUM_TAPS];
    out_word_t                expected_q [$];
    int                       mismatches;

    function new();
      fb_coef[0] = FB_COEF_Y1_RST;
      fb_coef[1] = FB_COEF_Y2_RST;
      fb_coef[2] = FB_COEF_Y3_RST;
      fb_coef[3] = FB_COEF_Y4_RST;
      scale      = INPUT_SCALE_RST;
      alt_taps   = NUM_MODE_RST;
      for (int i = 0; i < NUM_TAPS; i++) begin
        x_hist[i] = '0;
        y_hist[i] = '0;
      end
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (cfg_reg_e'(idx))
        REG_FB_COEF_Y4:  fb_coef[3] = data[COEF_W-1:0];
        REG_FB_COEF_Y3:  fb_coef[2] = data[COEF_W-1:0];
        REG_FB_COEF_Y2:  fb_coef[1] = data[COEF_W-1:0];
        REG_FB_COEF_Y1:  fb_coef[0] = data[COEF_W-1:0];
        REG_INPUT_SCALE: scale      = data[SCALE_W-1:0];
        REG_NUM_MODE:    alt_taps   = data[0];
        default: ;
      endcase
    endfunction

    // one filter step: feed-forward sum times scale plus feedback, round, saturate
    function void note_sample(logic [SW-1:0] x_raw, logic last);
      logic signed [SW-1:0]     x;
      logic signed [31:0]       ff;
      logic signed [127:0]      acc;
      logic signed [127:0]      ffv;
      logic signed [127:0]      scv;
      logic signed [127:0]      yv;
      logic signed [127:0]      cv;
      logic signed [WIDE_W-1:0] wide;
      out_word_t                res;
      int                       k;
      x   = x_raw;
      k   = alt_taps ? -4 : 4;
      ff  = x + k * x_hist[0] + 6 * x_hist[1] + k * x_hist[2] + x_hist[3];
      ffv = ff;
      scv = {80'd0, scale};
      acc = ffv * scv;
      for (int i = 0; i < NUM_TAPS; i++) begin
        yv  = y_hist[i];
        cv  = fb_coef[i];
        acc = acc + ((yv * cv) <<< FB_SHIFT);
      end
      acc = (acc + ROUND_HALF) >>> SCALE_FRAC_BITS;

      if (acc > WIDE_HI) wide = WIDE_HI[WIDE_W-1:0];
      else if (acc < WIDE_LO) wide = WIDE_LO[WIDE_W-1:0];
      else wide = acc[WIDE_W-1:0];

      if (acc > SAMP_HI) res.sample = SAMP_HI[SW-1:0];
      else if (acc < SAMP_LO) res.sample = SAMP_LO[SW-1:0];
      else res.sample = acc[SW-1:0];
      res.sat  = (acc > SAMP_HI) || (acc < SAMP_LO);
      res.last = last;
      expected_q.push_back(res);

      for (int i = NUM_TAPS - 1; i > 0; i--) begin
        x_hist[i] = x_hist[i-1];
        y_hist[i] = y_hist[i-1];
      end
      x_hist[0] = x;
      y_hist[0] = wide;
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (expected_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected output word: sample %0d sat %b last %b",
                   $signed(got.sample), got.sat, got.last);
        mismatches++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (got != exp_w) begin
        if (mismatches < 10)
          $display("mismatch: expected sample %0d sat %b last %b, got sample %0d sat %b last %b",
                   $signed(exp_w.sample), exp_w.sat, exp_w.last,
                   $signed(got.sample), got.sat, got.last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [SW-1:0]         s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [SW-1:0]         m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  filter_scoreboard sb;
  int               burst_left = 0;
  int               cycles = 0;
  int               rdy_left = 0;
  int               rdy_mode = 0;
  logic [31:0]      rdy_pat = '0;
  out_word_t        out_word;

  iir4_direct_form_filter_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // output side stalls: always ready, random, or a rotating bit pattern
  always @(negedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 2);
      rdy_left = $urandom_range(8, 40);
      rdy_pat  = $urandom;
    end
    rdy_left--;
    case (rdy_mode)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = ($urandom_range(0, 3) != 0);
      default: begin
        m_axis_tready = rdy_pat[0];
        rdy_pat = {rdy_pat[0], rdy_pat[31:1]};
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      out_word.sample = m_axis_tdata;
      out_word.sat    = m_axis_tuser;
      out_word.last   = m_axis_tlast;
      sb.check_result(out_word);
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input logic [SW-1:0] smp, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = smp;
    s_axis_tlast  = last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_sample(smp, last);
    @(negedge clk_i);
  endtask

  // stop the stream and let the filter go quiet before touching registers
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending() > 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic write_coefs(input logic [CFG_DATA_W-1:0] c4, input logic [CFG_DATA_W-1:0] c3,
                             input logic [CFG_DATA_W-1:0] c2, input logic [CFG_DATA_W-1:0] c1);
    write_reg(REG_FB_COEF_Y4, c4);
    write_reg(REG_FB_COEF_Y3, c3);
    write_reg(REG_FB_COEF_Y2, c2);
    write_reg(REG_FB_COEF_Y1, c1);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_wdata();
    return CFG_DATA_W'({$urandom, $urandom});
  endfunction

  task automatic apply_setting(input int ph);
    case (ph)
      1: write_reg(REG_NUM_MODE, 48'd1);
      2: begin
        // second pole set, DC gain near 1
        write_coefs(-48'sd127105921, 48'sd602917760, -48'sd1082806459, 48'sd874178669);
        write_reg(REG_INPUT_SCALE, 48'd82012231000);
        write_reg(REG_NUM_MODE, 48'd0);
      end
      3: begin
        // everything at the top: the wide value runs into its own limit
        write_coefs(48'h7fffffff, 48'h7fffffff, 48'h7fffffff, 48'h7fffffff);
        write_reg(REG_INPUT_SCALE, {CFG_DATA_W{1'b1}});
        write_reg(REG_NUM_MODE, 48'd1);
      end
      4: begin
        write_coefs(48'h80000000, 48'h80000000, 48'h80000000, 48'h80000000);
        write_reg(REG_INPUT_SCALE, 48'd0);
        write_reg(REG_NUM_MODE, 48'd0);
        write_reg(SPARE_IDX_LO, rand_wdata());
        write_reg(SPARE_IDX_HI, rand_wdata());
      end
      5: begin
        write_coefs(rand_wdata(), rand_wdata(), rand_wdata(), rand_wdata());
        write_reg(REG_INPUT_SCALE, rand_wdata());
        write_reg(REG_NUM_MODE, rand_wdata());
        write_reg(SPARE_IDX_HI, rand_wdata());
        write_reg(SPARE_IDX_LO, rand_wdata());
      end
      default: begin
        write_coefs(CFG_DATA_W'(FB_COEF_Y4_RST), CFG_DATA_W'(FB_COEF_Y3_RST),
                    CFG_DATA_W'(FB_COEF_Y2_RST), CFG_DATA_W'(FB_COEF_Y1_RST));
        write_reg(REG_INPUT_SCALE, 48'($urandom_range(1, 1 << 25)));
        write_reg(REG_NUM_MODE, 48'($urandom_range(0, 1)));
      end
    endcase
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: return SW'($signed($urandom_range(0, 31)) - 16);
      default: return SW'($urandom);
    endcase
  endfunction

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // step up to full scale and back down to the bottom, with clipping on the way
    send_word('0, 1'b0);
    repeat (6) send_word(S_MAX, 1'b0);
    send_word(S_MAX, 1'b1);
    repeat (6) send_word(S_MIN, 1'b0);
    send_word(SW'(1), 1'b1);
    send_word({SW{1'b1}}, 1'b0);
    send_word('0, 1'b1);

    // alternating taps on an alternating input
    drain();
    write_reg(REG_NUM_MODE, 48'd1);
    cfg_we_i = 1'b0;
    send_word(S_MAX, 1'b0);
    send_word(S_MIN, 1'b0);
    send_word(S_MAX, 1'b0);
    send_word(S_MIN, 1'b1);
    drain();
    write_reg(REG_NUM_MODE, 48'd0);
    cfg_we_i = 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        apply_setting(ph);
      end
      repeat (PHASE_ITEMS) send_word(rand_sample(), ($urandom_range(0, 7) == 0));
    end

    s_axis_tvalid = 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/iir4_pkg.sv
rtl/iir4_fb_sum.sv
rtl/iir4_direct_form_filter_top.sv
rtl/iir4_checker.sv
dv/tb.sv
